/* design/rgbe_srd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the RGBE-to-binary32 channel conversion for the
// scanline decoder. No dependencies.
package rgbe_srd_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_PIXEL = 3'd0,
        ST_DONE  = 3'd1,
        ST_EARLY = 3'd2,
        ST_TRUNC = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        t_status     status;
    } t_res;

    localparam int unsigned MIN_RLE_WIDTH = 8;
    localparam int unsigned MAX_RLE_WIDTH = 32'h7fff;

    // Mantissa byte m times 2^(e-136) as binary32 bits; +0 for m or e zero
    function automatic logic [31:0] rgbe_to_f32(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  k;
        logic [9:0]  ke;
        logic [31:0] mant;
        logic [31:0] res;
        k = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (m[i]) begin
                k = 3'(i);
            end
        end
        ke = 10'(k) + 10'(e);
        mant = 32'(m) << (5'd23 - 5'(k));
        if (m == 8'd0 || e == 8'd0) begin
            res = 32'd0;
        end else if (ke >= 10'd10) begin
            res = {1'b0, 8'(ke - 10'd9), mant[22:0]};
        end else begin
            res = 32'(m) << (5'(e) + 5'd13);
        end
        return res;
    endfunction

endpackage

/* design/rgbe_srd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts command requests and holds them in a two-entry queue
// for the back end. Depends on rgbe_srd_pkg.
module rgbe_srd_front
    import rgbe_srd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cmd_item i_item,
    output logic      o_head_valid,
    output t_cmd_item o_head,
    input  logic      i_pop
);

    t_cmd_item  r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && (r_count != 2'd0);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    // Store incoming request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

/* design/rgbe_srd_back.sv */
`timescale 1ns / 1ps
// Back end: line decoder sequencer and line store; executes queued requests
// and hands results to the output stage. Depends on rgbe_srd_pkg.
module rgbe_srd_back
    import rgbe_srd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [12:0] i_line_width,
    input  logic        i_head_valid,
    input  t_cmd_item   i_head,
    output logic        o_pop,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_res_ready
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned PW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW = (PW > 13) ? PW : 13;

    typedef enum logic [3:0] {
        S_EXEC   = 4'b0001,
        S_FILL   = 4'b0010,
        S_READ   = 4'b0100,
        S_REPORT = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        M_DETECT = 4'b0001,
        M_CH     = 4'b0010,
        M_OLD    = 4'b0100,
        M_DONE   = 4'b1000
    } t_mode;

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    logic [23:0] r_hdr, n_hdr;
    logic [1:0]  r_ch, n_ch;
    logic [CW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_rp, n_rp;
    logic [7:0]  r_run, n_run;
    logic        r_rep, n_rep;
    logic [4:0]  r_shift, n_shift;
    logic [23:0] r_pp, n_pp;
    logic [1:0]  r_pc, n_pc;
    logic [23:0] r_cnt, n_cnt;
    logic [7:0]  r_fill_val, n_fill_val;
    logic        r_fill_end, n_fill_end;
    logic [31:0] r_last_px, n_last_px;

    logic [CW-1:0] w;
    logic [15:0]   w16;
    logic [3:0]    lane_we;
    logic [31:0]   lane_wd;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [31:0]   r_rd_q;

    // Channel skip results
    t_mode         sk_mode;
    logic [1:0]    sk_ch;
    logic [CW-1:0] sk_wp;
    logic [7:0]    sk_run;
    logic          sk_rep;

    logic [7:0]    b, b1, b2;
    logic [31:0]   px;
    logic [CW-1:0] wp_inc;
    logic [4:0]    shift_inc;

    assign w   = (CW'(i_line_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(i_line_width);
    assign w16 = 16'(w);
    assign b   = i_head.data;

    // Line store, one byte lane per channel
    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0] mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (lane_we[g]) begin
                mem[wr_addr] <= lane_wd[g*8 +: 8];
            end
            if (rd_en) begin
                r_rd_q[g*8 +: 8] <= mem[r_rp[AW-1:0]];
            end
        end
    end

    // Leave a full channel before decoding the next byte
    always_comb begin
        sk_mode = r_mode;
        sk_ch   = r_ch;
        sk_wp   = r_wp;
        sk_run  = r_run;
        sk_rep  = r_rep;
        if (r_mode == M_CH && r_wp >= w) begin
            sk_wp  = '0;
            sk_run = 8'd0;
            sk_rep = 1'b0;
            if (w == '0) begin
                sk_mode = M_DONE;
                sk_ch   = 2'd3;
            end else if (r_ch == 2'd3) begin
                sk_mode = M_DONE;
            end else begin
                sk_ch = r_ch + 2'd1;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_hdr      = r_hdr;
        n_ch       = r_ch;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_run      = r_run;
        n_rep      = r_rep;
        n_shift    = r_shift;
        n_pp       = r_pp;
        n_pc       = r_pc;
        n_cnt      = r_cnt;
        n_fill_val = r_fill_val;
        n_fill_end = r_fill_end;
        n_last_px  = r_last_px;
        lane_we    = 4'b0000;
        lane_wd    = 32'd0;
        wr_addr    = r_wp[AW-1:0];
        rd_en      = 1'b0;
        o_pop      = 1'b0;
        o_res_valid = 1'b0;
        o_res      = '{pixel: 32'd0, last: 1'b0, status: ST_PIXEL};
        b1         = r_hdr[7:0];
        b2         = r_hdr[15:8];
        px         = {b, r_pp};
        wp_inc     = r_wp + CW'(1);
        shift_inc  = r_shift + 5'd8;

        case (r_state)
            S_EXEC: begin
                if (i_head_valid) begin
                    case (i_head.cmd)
                        CMD_START: begin
                            o_pop   = 1'b1;
                            n_mode  = M_DETECT;
                            n_hdr   = 24'd0;
                            n_ch    = 2'd0;
                            n_wp    = '0;
                            n_rp    = '0;
                            n_run   = 8'd0;
                            n_rep   = 1'b0;
                            n_shift = 5'd0;
                            n_pp    = 24'd0;
                            n_pc    = 2'd0;
                        end
                        CMD_BYTE: begin
                            o_pop = 1'b1;
                            case (r_mode)
                                M_DETECT: begin
                                    if (r_pc == 2'd0) begin
                                        n_pc = 2'd1;
                                        if (w16 < 16'(MIN_RLE_WIDTH) || w16 > 16'(MAX_RLE_WIDTH)
                                            || b != 8'd2) begin
                                            n_mode  = M_OLD;
                                            n_wp    = '0;
                                            n_shift = 5'd0;
                                            n_pp    = {16'd0, b};
                                        end
                                    end else if (r_pc == 2'd3) begin
                                        n_pc    = 2'd0;
                                        n_hdr   = 24'd0;
                                        wr_addr = '0;
                                        if (b1 != 8'd2 || b2[7]) begin
                                            lane_we   = 4'b1111;
                                            lane_wd   = {b, b2, b1, 8'd2};
                                            n_last_px = {b, b2, b1, 8'd2};
                                            n_wp      = CW'(1);
                                            n_shift   = 5'd0;
                                            n_mode    = (w <= CW'(1)) ? M_DONE : M_OLD;
                                        end else begin
                                            lane_we = 4'b0110;
                                            lane_wd = {8'd0, b2, b1, 8'd0};
                                            n_mode  = M_CH;
                                            n_ch    = 2'd0;
                                            n_wp    = '0;
                                            n_run   = 8'd0;
                                            n_rep   = 1'b0;
                                        end
                                    end else begin
                                        n_hdr = r_hdr | (24'(b) << {r_pc - 2'd1, 3'd0});
                                        n_pc  = r_pc + 2'd1;
                                    end
                                end
                                M_OLD: begin
                                    if (r_pc != 2'd3) begin
                                        n_pp = r_pp | (24'(b) << {r_pc, 3'd0});
                                        n_pc = r_pc + 2'd1;
                                    end else begin
                                        n_pp = 24'd0;
                                        n_pc = 2'd0;
                                        if (r_wp >= w) begin
                                            n_mode = M_DONE;
                                        end else if (px[23:0] == 24'h010101) begin
                                            // Repeat run of the previous pixel
                                            n_cnt      = (r_wp != '0) ? (24'(b) << r_shift) : 24'd0;
                                            n_fill_end = 1'b0;
                                            n_state    = S_FILL;
                                        end else begin
                                            lane_we   = 4'b1111;
                                            lane_wd   = px;
                                            n_last_px = px;
                                            n_wp      = wp_inc;
                                            n_shift   = 5'd0;
                                            if (wp_inc >= w) n_mode = M_DONE;
                                        end
                                    end
                                end
                                M_CH: begin
                                    n_mode = sk_mode;
                                    n_ch   = sk_ch;
                                    n_wp   = sk_wp;
                                    n_run  = sk_run;
                                    n_rep  = sk_rep;
                                    if (sk_mode == M_CH) begin
                                        if (sk_run == 8'd0) begin
                                            if (b > 8'd128) begin
                                                n_rep = 1'b1;
                                                n_run = {1'b0, b[6:0]};
                                            end else if (b != 8'd0) begin
                                                n_rep = 1'b0;
                                                n_run = b;
                                            end
                                        end else if (sk_rep) begin
                                            n_run      = 8'd0;
                                            n_rep      = 1'b0;
                                            n_cnt      = 24'(sk_run);
                                            n_fill_val = b;
                                            n_fill_end = 1'b0;
                                            n_state    = S_FILL;
                                        end else begin
                                            // One literal
                                            wr_addr = sk_wp[AW-1:0];
                                            lane_we[sk_ch] = 1'b1;
                                            lane_wd = {4{b}};
                                            n_run = sk_run - 8'd1;
                                            n_wp  = sk_wp + CW'(1);
                                            if (sk_wp + CW'(1) >= w) begin
                                                n_wp  = '0;
                                                n_run = 8'd0;
                                                n_rep = 1'b0;
                                                if (sk_ch == 2'd3) n_mode = M_DONE;
                                                else n_ch = sk_ch + 2'd1;
                                            end
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        CMD_READ: begin
                            if (r_rp >= w) begin
                                if (i_res_ready) begin
                                    o_pop        = 1'b1;
                                    o_res_valid  = 1'b1;
                                    o_res.status = ST_EMPTY;
                                end
                            end else begin
                                o_pop   = 1'b1;
                                rd_en   = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // End of data
                            if (r_mode == M_CH && sk_mode == M_CH && sk_run != 8'd0) begin
                                o_pop      = 1'b1;
                                n_ch       = sk_ch;
                                n_wp       = sk_wp;
                                n_run      = 8'd0;
                                n_rep      = 1'b0;
                                n_cnt      = 24'(sk_run);
                                n_fill_val = 8'd0;
                                n_fill_end = 1'b1;
                                n_state    = S_FILL;
                            end else if (i_res_ready) begin
                                o_pop       = 1'b1;
                                o_res_valid = 1'b1;
                                case (r_mode)
                                    M_DONE: o_res.status = ST_DONE;
                                    M_OLD:  o_res.status = (r_wp >= w) ? ST_DONE : ST_TRUNC;
                                    M_CH: begin
                                        n_mode = sk_mode;
                                        n_ch   = sk_ch;
                                        n_wp   = sk_wp;
                                        n_run  = sk_run;
                                        n_rep  = sk_rep;
                                        o_res.status = (sk_mode == M_DONE) ? ST_DONE : ST_EARLY;
                                    end
                                    default: begin
                                        if (r_pc == 2'd0) begin
                                            o_res.status = (w == '0) ? ST_DONE : ST_TRUNC;
                                        end else begin
                                            b1 = (r_pc >= 2'd2) ? r_hdr[7:0] : 8'd0;
                                            b2 = (r_pc == 2'd3) ? r_hdr[15:8] : 8'd0;
                                            o_res.status = (b1 != 8'd2 || b2[7]) ? ST_TRUNC
                                                                                 : ST_EARLY;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                // Write one pixel of the run per cycle
                if (r_cnt != 24'd0 && r_wp < w) begin
                    if (r_mode == M_OLD) begin
                        lane_we = 4'b1111;
                        lane_wd = r_last_px;
                    end else begin
                        lane_we[r_ch] = 1'b1;
                        lane_wd = {4{r_fill_val}};
                    end
                    n_wp  = wp_inc;
                    n_cnt = r_cnt - 24'd1;
                end else if (r_mode == M_OLD) begin
                    n_shift = shift_inc;
                    if (shift_inc > 5'd16 || r_wp >= w) n_mode = M_DONE;
                    n_state = S_EXEC;
                end else begin
                    if (r_wp >= w) begin
                        n_wp  = '0;
                        n_run = 8'd0;
                        n_rep = 1'b0;
                        if (r_ch == 2'd3) n_mode = M_DONE;
                        else n_ch = r_ch + 2'd1;
                    end
                    n_state = r_fill_end ? S_REPORT : S_EXEC;
                end
            end
            S_READ: begin
                if (i_res_ready) begin
                    o_res_valid  = 1'b1;
                    o_res.pixel  = r_rd_q;
                    o_res.last   = (r_rp + CW'(1) == w);
                    o_res.status = ST_PIXEL;
                    n_rp         = r_rp + CW'(1);
                    n_state      = S_EXEC;
                end
            end
            S_REPORT: begin
                if (i_res_ready) begin
                    o_res_valid  = 1'b1;
                    o_res.status = (r_mode == M_DONE) ? ST_DONE : ST_EARLY;
                    n_state      = S_EXEC;
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EXEC;
            r_mode  <= M_DETECT;
            r_hdr   <= 24'd0;
            r_ch    <= 2'd0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_run   <= 8'd0;
            r_rep   <= 1'b0;
            r_shift <= 5'd0;
            r_pp    <= 24'd0;
            r_pc    <= 2'd0;
            r_cnt   <= 24'd0;
            r_fill_end <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_hdr   <= n_hdr;
            r_ch    <= n_ch;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_run   <= n_run;
            r_rep   <= n_rep;
            r_shift <= n_shift;
            r_pp    <= n_pp;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_fill_end <= n_fill_end;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fill_val <= n_fill_val;
        r_last_px  <= n_last_px;
    end

    a_fill_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !o_res_valid)
        else $error("result offered during a run fill");

    a_pop_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_EXEC) && i_head_valid)
        else $error("request popped outside of dispatch");

    a_read_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_state == S_READ))
        else $error("store read issued without waiting for data");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_we != 4'b0000) |-> (32'(wr_addr) < MAX_WIDTH))
        else $error("line store write out of range");

endmodule

/* design/rgbe_srd_out.sv */
`timescale 1ns / 1ps
// Output stage: converts a stored RGBE pixel to three binary32 values and
// holds the result until taken. Depends on rgbe_srd_pkg.
module rgbe_srd_out
    import rgbe_srd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  t_res        i_res,
    output logic        o_res_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [95:0] o_data,
    output logic        o_last,
    output t_status     o_status
);

    logic r_valid;

    assign o_res_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;

    // Track result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    // Convert and load result
    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            o_last   <= i_res.last;
            o_status <= i_res.status;
            if (i_res.status == ST_PIXEL) begin
                o_data <= {rgbe_to_f32(i_res.pixel[23:16], i_res.pixel[31:24]),
                           rgbe_to_f32(i_res.pixel[15:8],  i_res.pixel[31:24]),
                           rgbe_to_f32(i_res.pixel[7:0],   i_res.pixel[31:24])};
            end else begin
                o_data <= 96'd0;
            end
        end
    end

endmodule

/* design/rgbe_scanline_rle_decoder.sv */
`timescale 1ns / 1ps
// RGBE scanline run-length decoder, top level. Uses rgbe_srd_pkg,
// rgbe_srd_front, rgbe_srd_back and rgbe_srd_out.
//
// Each request (start line, data byte, read pixel, end of data) is queued and
// then executed by a sequencer over a MAX_WIDTH x 32-bit line store. Start line
// and data bytes are executed directly, except that a repeat run is then written
// one pixel per cycle through the single store write port. A pixel read is a
// registered store read, then conversion into the output register; end of data
// reports directly, or first writes the pending run pixels and then reports.
// Reads and reports come out as m_axis items: status in tuser, the last pixel of
// the line flagged in tlast. The line store is not cleared: pixels must be
// written by the current or an earlier line before they are read.
module rgbe_scanline_rle_decoder
    import rgbe_srd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,     // line_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,    // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,    // [31:0] red, [63:32] green, [95:64] blue
    output logic        m_axis_tlast,    // last_pixel
    output logic [2:0]  m_axis_tuser     // [2:0] status
);

    logic [12:0] r_line_width;
    t_cmd_item   in_item, head;
    logic        head_valid, pop;
    logic        res_valid, res_ready;
    t_res        res;
    t_status     out_status;

    // Hold line width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 13'd1;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_wdata;
        end
    end

    assign in_item = '{cmd: t_cmd'(s_axis_tuser), data: s_axis_tdata};

    rgbe_srd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    rgbe_srd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    rgbe_srd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_status    (out_status)
    );

    assign m_axis_tuser = 3'(out_status);

endmodule

/* verif/rgbe_scanline_rle_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rgbe_scanline_rle_decoder: drives request streams, predicts
// every pixel and report from a behavioral copy of the line decoder. Uses rgbe_srd_pkg.
module rgbe_scanline_rle_decoder_tb;
    import rgbe_srd_pkg::*;

    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE      = 4200;
    localparam int unsigned ITEM_GOAL   = 1100;
    // decode phases of the predictor
    localparam int unsigned PH_DETECT  = 0;
    localparam int unsigned PH_CHANNEL = 1;
    localparam int unsigned PH_OLD     = 2;
    localparam int unsigned PH_DONE    = 3;

    typedef struct packed {
        logic [95:0] rgb;
        logic        last;
        logic [2:0]  status;
    } t_pixel_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [12:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // [31:0] red, [63:32] green, [95:64] blue
    logic        m_axis_tlast;         // last_pixel
    logic [2:0]  m_axis_tuser;         // [2:0] status

    rgbe_scanline_rle_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [31:0]   line_mem [0:STORE_DEPTH-1];
    int unsigned   width_reg = 1;
    int unsigned   phase, hdr, chan, wpos, run_left, run_rep, rep_shift, part_px, part_cnt;
    int unsigned   rpos;
    t_pixel_report pending_reports[$];

    int unsigned   sent = 0, checked = 0, mismatches = 0, lines = 0, cycles = 0;
    bit            calm = 1'b0;

    function automatic int unsigned eff_width();
        return (width_reg > STORE_DEPTH) ? STORE_DEPTH : width_reg;
    endfunction

    function automatic void clear_line();
        phase = PH_DETECT; hdr = 0; chan = 0; wpos = 0; run_left = 0; run_rep = 0;
        rep_shift = 0; part_px = 0; part_cnt = 0; rpos = 0;
    endfunction

    function automatic void set_lane(int unsigned pos, int unsigned lane, int unsigned v);
        if (pos < STORE_DEPTH) line_mem[pos][lane*8 +: 8] = v[7:0];
    endfunction

    function automatic void legacy_pixel(int unsigned px);
        int unsigned w, n;
        w = eff_width();
        if (wpos >= w) begin
            phase = PH_DONE;
            return;
        end
        if ((px & 32'hffffff) == 32'h010101) begin
            n = (px >> 24) << rep_shift;
            if (wpos >= 1) begin
                while (n > 0 && wpos < w) begin
                    line_mem[wpos] = line_mem[wpos-1];
                    wpos++;
                    n--;
                end
            end
            rep_shift += 8;
            if (rep_shift > 16) begin
                phase = PH_DONE;
                return;
            end
        end else begin
            line_mem[wpos] = px;
            wpos++;
            rep_shift = 0;
        end
        if (wpos >= w) phase = PH_DONE;
    endfunction

    function automatic void legacy_byte(int unsigned b);
        int unsigned px;
        if (part_cnt < 3) begin
            part_px |= b << (8 * part_cnt);
            part_cnt++;
        end else begin
            px = part_px | (b << 24);
            part_px = 0;
            part_cnt = 0;
            legacy_pixel(px);
        end
    endfunction

    function automatic void header_byte(int unsigned b);
        int unsigned w, b1, b2, b3;
        w = eff_width();
        if (part_cnt == 0) begin
            if (w < MIN_RLE_WIDTH || w > MAX_RLE_WIDTH || b != 2) begin
                phase = PH_OLD; wpos = 0; rep_shift = 0;
                legacy_byte(b);
            end else begin
                part_cnt = 1;
            end
            return;
        end
        hdr |= b << (8 * (part_cnt - 1));
        part_cnt++;
        if (part_cnt == 4) begin
            b1 = hdr & 8'hff; b2 = (hdr >> 8) & 8'hff; b3 = (hdr >> 16) & 8'hff;
            part_cnt = 0; hdr = 0;
            if (b1 != 2 || (b2 & 128) != 0) begin
                line_mem[0] = 2 | (b1 << 8) | (b2 << 16) | (b3 << 24);
                wpos = 1; rep_shift = 0;
                phase = (wpos >= w) ? PH_DONE : PH_OLD;
            end else begin
                set_lane(0, 1, b1);
                set_lane(0, 2, b2);
                phase = PH_CHANNEL; chan = 0; wpos = 0; run_left = 0; run_rep = 0;
            end
        end
    endfunction

    function automatic void advance_channel();
        wpos = 0; run_left = 0; run_rep = 0;
        if (chan >= 3) phase = PH_DONE;
        else chan++;
    endfunction

    function automatic void skip_full();
        while (phase == PH_CHANNEL && wpos >= eff_width()) advance_channel();
    endfunction

    function automatic void fill_lane(int unsigned v, int unsigned n);
        while (n > 0 && wpos < eff_width()) begin
            set_lane(wpos, chan, v);
            wpos++;
            n--;
        end
        if (wpos >= eff_width()) advance_channel();
    endfunction

    function automatic void channel_byte(int unsigned b);
        int unsigned n;
        skip_full();
        if (phase != PH_CHANNEL) return;
        if (run_left == 0) begin
            if (b > 128) begin
                run_rep = 1; run_left = b & 127;
            end else if (b > 0) begin
                run_rep = 0; run_left = b;
            end
            return;
        end
        if (run_rep != 0) begin
            n = run_left; run_left = 0; run_rep = 0;
            fill_lane(b, n);
        end else begin
            run_left--;
            fill_lane(b, 1);
        end
    endfunction

    function automatic t_status end_report();
        int unsigned w, n, b1, b2;
        w = eff_width();
        if (phase == PH_DONE) return ST_DONE;
        if (phase == PH_OLD) return (wpos >= w) ? ST_DONE : ST_TRUNC;
        if (phase == PH_CHANNEL) begin
            skip_full();
            if (phase == PH_CHANNEL && run_left > 0) begin
                n = run_left; run_left = 0; run_rep = 0;
                fill_lane(0, n);
            end
            return (phase == PH_DONE) ? ST_DONE : ST_EARLY;
        end
        if (part_cnt == 0) return (w == 0) ? ST_DONE : ST_TRUNC;
        b1 = (part_cnt >= 2) ? (hdr & 8'hff) : 0;
        b2 = (part_cnt >= 3) ? ((hdr >> 8) & 8'hff) : 0;
        return (b1 != 2 || (b2 & 128) != 0) ? ST_TRUNC : ST_EARLY;
    endfunction

    // Mantissa byte times 2^(e-136) as binary32
    function automatic logic [31:0] lane_to_float(int unsigned m, int unsigned e);
        int unsigned k;
        int          biased;
        k = 0;
        if (m == 0 || e == 0) return 32'd0;
        while ((m >> (k + 1)) != 0) k++;
        biased = int'(k) + int'(e) - 9;
        if (biased >= 1) return (biased << 23) | ((m << (23 - k)) & 32'h7fffff);
        return m << (e + 13);
    endfunction

    // Apply one accepted request to the predictor; queue the report it causes
    function automatic void predict_request(t_cmd cmd, logic [7:0] b);
        t_pixel_report r;
        logic [31:0]   px;
        r = '0;
        case (cmd)
            CMD_START: begin
                clear_line();
                return;
            end
            CMD_BYTE: begin
                if (phase == PH_DETECT) header_byte(b);
                else if (phase == PH_OLD) legacy_byte(b);
                else if (phase == PH_CHANNEL) channel_byte(b);
                return;
            end
            CMD_END: r.status = end_report();
            default: begin
                if (rpos >= eff_width()) begin
                    r.status = ST_EMPTY;
                end else begin
                    px = line_mem[rpos];
                    r.rgb = {lane_to_float(px[23:16], px[31:24]),
                             lane_to_float(px[15:8], px[31:24]),
                             lane_to_float(px[7:0], px[31:24])};
                    r.last = (rpos + 1 == eff_width());
                    r.status = ST_PIXEL;
                    rpos++;
                end
            end
        endcase
        pending_reports.push_back(r);
    endfunction

    // Send one request, with random gaps before it outside the calm part
    task automatic send(t_cmd cmd, logic [7:0] b = 8'd0);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(cmd, b);
        sent++;
    endtask

    // Hold the sender until every report is back and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_width(int unsigned w);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w[12:0];
        @(posedge i_clk);
        width_reg = w & 13'h1fff;
        i_cfg_we <= 1'b0;
    endtask

    task automatic read_pixels(int unsigned n);
        repeat (n) send(CMD_READ);
    endtask

    // Per-channel coded line; broken lines stop early or carry noise codes
    task automatic rle_line(int unsigned w, bit broken);
        int unsigned pos, n, stop;
        send(CMD_START);
        send(CMD_BYTE, 8'd2);
        send(CMD_BYTE, 8'd2);
        send(CMD_BYTE, 8'($urandom_range(0, 127)));
        send(CMD_BYTE, 8'($urandom));
        stop = broken ? $urandom_range(0, 4 * w) : 4 * w + 1;
        for (int ch = 0; ch < 4; ch++) begin
            pos = 0;
            while (pos < w && ch * w + pos < stop) begin
                if (broken && $urandom_range(0, 7) == 0) send(CMD_BYTE, 8'd0);
                if ($urandom_range(0, 1) == 0) begin
                    n = $urandom_range(1, (w - pos > 127) ? 127 : w - pos);
                    send(CMD_BYTE, 8'(128 + n));
                    send(CMD_BYTE, 8'($urandom));
                end else begin
                    n = $urandom_range(1, (w - pos > 128) ? 128 : w - pos);
                    send(CMD_BYTE, 8'(n));
                    for (int i = 0; i < n && ch * w + pos + i < stop; i++)
                        send(CMD_BYTE, 8'($urandom));
                end
                pos += n;
            end
        end
        read_pixels(w + $urandom_range(0, 2));
        send(CMD_END);
        lines++;
    endtask

    // Old-scheme line: 4-byte pixels with occasional repeat runs
    task automatic legacy_line(int unsigned w, bit broken);
        int unsigned npx;
        send(CMD_START);
        npx = broken ? $urandom_range(0, w) : w;
        for (int p = 0; p < npx; p++) begin
            if (p > 0 && $urandom_range(0, 5) == 0) begin
                send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1);
                send(CMD_BYTE, 8'($urandom_range(0, 3)));
            end else begin
                send(CMD_BYTE, 8'((p == 0) ? $urandom_range(3, 255) : $urandom));
                repeat (3) send(CMD_BYTE, 8'($urandom));
            end
        end
        if (broken) repeat ($urandom_range(0, 3)) send(CMD_BYTE, 8'($urandom));
        read_pixels(w + $urandom_range(0, 2));
        send(CMD_END);
        if ($urandom_range(0, 3) == 0) send(CMD_END);
        lines++;
    endtask

    // Fill the whole store through one wide old-scheme line
    task automatic test_store_fill();
        write_width(STORE_DEPTH);
        send(CMD_START);
        send(CMD_BYTE, 8'd0); send(CMD_BYTE, 8'hff); send(CMD_BYTE, 8'h80);
        send(CMD_BYTE, 8'hff);
        repeat (2) begin
            send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1);
            send(CMD_BYTE, 8'hff);
        end
        read_pixels(2);
        send(CMD_END);
        send(CMD_BYTE, 8'h55);    // ignored once the line is done
        lines++;
    endtask

    // Extreme widths, header-detection end reports, repeated end reports
    task automatic test_corner_widths();
        write_width(0);
        send(CMD_START); send(CMD_END); send(CMD_READ);
        write_width(13'h1fff);
        send(CMD_START); send(CMD_END);
        send(CMD_BYTE, 8'd2); send(CMD_END);
        send(CMD_BYTE, 8'd2); send(CMD_END);
        send(CMD_BYTE, 8'h80); send(CMD_END); send(CMD_END);
        send(CMD_READ);
        write_width(8);
        send(CMD_START); send(CMD_BYTE, 8'd2); send(CMD_BYTE, 8'd3);
        send(CMD_BYTE, 8'd0); send(CMD_BYTE, 8'd1);
        read_pixels(2); send(CMD_END);
        send(CMD_START); send(CMD_BYTE, 8'd2); send(CMD_BYTE, 8'd2);
        send(CMD_BYTE, 8'd0); send(CMD_BYTE, 8'd8);
        send(CMD_BYTE, 8'd0); send(CMD_BYTE, 8'd136);   // repeat left pending
        send(CMD_END); send(CMD_END);
        read_pixels(9);
    endtask

    // Width changed while a line is half decoded
    task automatic test_width_change();
        write_width(16);
        send(CMD_START); send(CMD_BYTE, 8'd2); send(CMD_BYTE, 8'd2);
        send(CMD_BYTE, 8'd0); send(CMD_BYTE, 8'd16);
        send(CMD_BYTE, 8'd140); send(CMD_BYTE, 8'h3c);
        write_width(9);
        repeat (8) send(CMD_BYTE, 8'($urandom));
        send(CMD_END); read_pixels(10);
        write_width(1);
        send(CMD_START); repeat (4) send(CMD_BYTE, 8'hff);
        read_pixels(2); send(CMD_END);
        write_width(3);
        send(CMD_START); repeat (4) send(CMD_BYTE, 8'h00);
        repeat (3) begin
            send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1); send(CMD_BYTE, 8'd1);
            send(CMD_BYTE, 8'd0);
        end
        send(CMD_END); read_pixels(4);
    endtask

    // Wide lines only while the request budget is large, one line each
    task automatic test_random_lines();
        int unsigned w, goal;
        goal = sent + ITEM_GOAL;
        while (sent < goal) begin
            calm = (goal - sent) < 200;
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(1, 7);
                1:       w = (goal - sent > 900) ? $urandom_range(100, 200)
                                                 : $urandom_range(8, 24);
                default: w = $urandom_range(8, 24);
            endcase
            write_width(w);
            repeat ((w > 64) ? 1 : $urandom_range(1, 3)) begin
                if (w >= MIN_RLE_WIDTH && $urandom_range(0, 2) != 0)
                    rle_line(w, $urandom_range(0, 4) == 0);
                else
                    legacy_line(w, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // Result check and receiver stalls
    always @(posedge i_clk) begin
        t_pixel_report want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected report status %0d", m_axis_tuser);
            end else begin
                want = pending_reports.pop_front();
                checked++;
                if (m_axis_tdata !== want.rgb || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report %0d: exp rgb %h last %b st %0d, got %h %b %0d",
                                 checked, want.rgb, want.last, want.status,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 4) != 0);
    end

    // Hard stop
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_line();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_fill();
        test_corner_widths();
        test_width_change();
        test_random_lines();
        drain();
        $display("%0d requests, %0d lines, %0d reports checked, %0d mismatches",
                 sent, lines, checked, mismatches);
        $display("widths 0 to 8191, both line codings, early ends and past-line reads");
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
